// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the fire frame update RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define FEFU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also covers the reset cycles.
`define FEFU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/fefu_pkg.sv =====
// ----------------------------------------------------------------------------
// fefu_pkg
// Types and constants of the fire frame update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fefu_pkg;

   // width used to compare coordinates against the frame size
   localparam int COORD_W = 11;

   localparam logic [1:0] OP_SEED = 2'd0;
   localparam logic [1:0] OP_STEP = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [2:0] REG_WARM      = 3'd0;
   localparam logic [2:0] REG_COLD      = 3'd1;
   localparam logic [2:0] REG_COOL_HI   = 3'd2;
   localparam logic [2:0] REG_COOL_LO   = 3'd3;
   localparam logic [2:0] REG_COOL_COLD = 3'd4;

   localparam logic [7:0] WARM_RST      = 8'd70;
   localparam logic [7:0] COLD_RST      = 8'd20;
   localparam logic [3:0] COOL_HI_RST   = 4'd1;
   localparam logic [3:0] COOL_LO_RST   = 4'd3;
   localparam logic [3:0] COOL_COLD_RST = 4'd1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_STEP,
      S_DRAIN,
      S_DONE
   } fefu_state_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic scan_run;
      logic flip;
      logic load_rsp;
   } fefu_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_step;
      logic scan_last;
      logic pipe_busy;
   } fefu_status_type;

endpackage

`default_nettype wire

// ===== sv/fefu_frame_mem.sv =====
// ----------------------------------------------------------------------------
// fefu_frame_mem
// Heat store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fefu_frame_mem #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_a_en,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output logic [DATA_W-1:0] rd_a_data,
   input  logic              rd_b_en,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [DATA_W-1:0] rd_b_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

// ===== sv/fefu_datapath.sv =====
// ----------------------------------------------------------------------------
// fefu_datapath
// Frame banks, scan counters, neighbor window, cooling pipe and result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fefu_datapath #(
   parameter int FRAME_WIDTH  = 64,
   parameter int FRAME_HEIGHT = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fefu_pkg::fefu_cmd_type    cmd,
   output fefu_pkg::fefu_status_type st,
   input  logic [1:0]                req_opcode,
   input  logic [5:0]                req_column,
   input  logic [5:0]                req_row,
   input  logic                      req_seed_enable,
   input  logic [7:0]                req_seed_heat,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [7:0]                csr_wdata,
   output logic [7:0]                rsp_read_heat,
   output logic [1:0]                rsp_done_opcode
);

   localparam int CW     = $clog2(FRAME_WIDTH);
   localparam int RW     = $clog2(FRAME_HEIGHT);
   localparam int SW     = $clog2(FRAME_WIDTH + 1);
   localparam int PIX_W  = RW + CW;
   localparam int MEM_AW = PIX_W + 1;
   localparam int CRD_W  = fefu_pkg::COORD_W;

   function automatic logic [7:0] cool_heat(
      input logic [9:0] sum,
      input logic [7:0] warm,
      input logic [7:0] cold,
      input logic [3:0] dec_hi,
      input logic [3:0] dec_lo,
      input logic [3:0] dec_cold
   );
      logic signed [11:0] q;
      logic signed [11:0] warm_q;
      logic signed [11:0] cold_q;
      q      = $signed({2'b00, sum});
      warm_q = $signed({2'b00, warm, 2'b00});
      cold_q = $signed({2'b00, cold, 2'b00});
      if (q > warm_q) begin
         q = q - $signed({6'b000000, dec_hi, 2'b00});
      end
      if (q <= warm_q) begin
         q = q - $signed({6'b000000, dec_lo, 2'b00});
      end
      if (q < cold_q) begin
         q = q - $signed({6'b000000, dec_cold, 2'b00});
      end
      return q[11] ? 8'd0 : q[9:2];
   endfunction

   // configuration
   logic [7:0] warm_ff, warm_in;
   logic [7:0] cold_ff, cold_in;
   logic [3:0] cool_hi_ff, cool_hi_in;
   logic [3:0] cool_lo_ff, cool_lo_in;
   logic [3:0] cool_cold_ff, cool_cold_in;

   // control state
   logic             active_bank_ff, active_bank_in;
   logic [PIX_W-1:0] clr_addr_ff, clr_addr_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             s1_run_ff, s1_run_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s2_valid_ff, s2_valid_in;

   // payload
   logic             s1_interior_ff, s1_interior_in;
   logic [PIX_W-1:0] s1_addr_ff, s1_addr_in;
   logic             s2_interior_ff, s2_interior_in;
   logic [PIX_W-1:0] s2_addr_ff, s2_addr_in;
   logic [9:0]       s2_sum_ff, s2_sum_in;
   logic [7:0]       win0_ff, win0_in;
   logic [7:0]       win1_ff, win1_in;
   logic [1:0]       op_ff, op_in;
   logic             read_ok_ff, read_ok_in;
   logic [7:0]       rsp_heat_ff, rsp_heat_in;
   logic [1:0]       rsp_op_ff, rsp_op_in;

   // memory ports
   logic              wr_en;
   logic [MEM_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_a_en;
   logic [MEM_AW-1:0] rd_a_addr;
   logic [7:0]        rd_a_data;
   logic              rd_b_en;
   logic [MEM_AW-1:0] rd_b_addr;
   logic [7:0]        rd_b_data;

   logic          col_ok;
   logic          row_ok;
   logic [CW-1:0] req_col_idx;
   logic [RW-1:0] req_row_idx;
   logic [RW-1:0] row_p1;
   logic [RW-1:0] row_p2;
   logic [CW-1:0] slot_col;
   logic [CW-1:0] pix_col;
   logic          interior_issue;
   logic          pix_issue;
   logic          slot_last;
   logic          row_last;
   logic          seed_hit;
   logic          read_hit;

   assign col_ok      = (CRD_W'(req_column) < CRD_W'(FRAME_WIDTH));
   assign row_ok      = (CRD_W'(req_row) < CRD_W'(FRAME_HEIGHT));
   assign req_col_idx = CW'(req_column);
   assign req_row_idx = RW'(req_row);
   assign seed_hit    = cmd.accept && (req_opcode == fefu_pkg::OP_SEED) &&
                        req_seed_enable && col_ok;
   assign read_hit    = cmd.accept && (req_opcode == fefu_pkg::OP_READ);

   assign row_p1   = row_ff + RW'(1);
   assign row_p2   = row_ff + RW'(2);
   assign slot_col = CW'(slot_ff);
   assign pix_col  = CW'(slot_ff - SW'(1));
   assign pix_issue      = (slot_ff != '0);
   assign interior_issue = (row_ff < RW'(FRAME_HEIGHT - 2)) &&
                           (slot_ff >= SW'(2)) && (slot_ff < SW'(FRAME_WIDTH));
   assign slot_last = (slot_ff == SW'(FRAME_WIDTH));
   assign row_last  = (row_ff == RW'(FRAME_HEIGHT - 1));

   always_comb begin
      warm_in      = warm_ff;
      cold_in      = cold_ff;
      cool_hi_in   = cool_hi_ff;
      cool_lo_in   = cool_lo_ff;
      cool_cold_in = cool_cold_ff;
      if (csr_we) begin
         case (csr_index)
            fefu_pkg::REG_WARM:      warm_in      = csr_wdata;
            fefu_pkg::REG_COLD:      cold_in      = csr_wdata;
            fefu_pkg::REG_COOL_HI:   cool_hi_in   = csr_wdata[3:0];
            fefu_pkg::REG_COOL_LO:   cool_lo_in   = csr_wdata[3:0];
            fefu_pkg::REG_COOL_COLD: cool_cold_in = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // scan: one slot per column plus a fill slot ahead of each row; clear address and bank flip
   always_comb begin
      slot_in        = slot_ff;
      row_in         = row_ff;
      clr_addr_in    = cmd.clear_en ? clr_addr_ff + PIX_W'(1) : clr_addr_ff;
      active_bank_in = cmd.flip ? ~active_bank_ff : active_bank_ff;
      if (cmd.scan_run) begin
         if (slot_last) begin
            slot_in = '0;
            row_in  = row_last ? '0 : row_p1;
         end else begin
            slot_in = slot_ff + SW'(1);
         end
      end
   end

   always_comb begin
      rd_a_en   = cmd.scan_run || read_hit;
      rd_a_addr = cmd.scan_run ? {active_bank_ff, row_p1, slot_col}
                               : {active_bank_ff, req_row_idx, req_col_idx};
      rd_b_en   = cmd.scan_run;
      rd_b_addr = {active_bank_ff, (interior_issue ? row_p2 : row_ff), pix_col};
   end

   // window holds row r+1 at columns c-1 and c
   always_comb begin
      s1_run_in      = cmd.scan_run;
      s1_valid_in    = cmd.scan_run && pix_issue;
      s1_interior_in = interior_issue;
      s1_addr_in     = {row_ff, pix_col};
      win0_in        = s1_run_ff ? rd_a_data : win0_ff;
      win1_in        = s1_run_ff ? win0_ff : win1_ff;
      s2_valid_in    = s1_valid_ff;
      s2_interior_in = s1_interior_ff;
      s2_addr_in     = s1_addr_ff;
      s2_sum_in      = s1_interior_ff ?
                       {2'b00, win1_ff} + {2'b00, win0_ff} +
                       {2'b00, rd_a_data} + {2'b00, rd_b_data}
                       : {2'b00, rd_b_data};
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {~active_bank_ff, s2_addr_ff};
      wr_data = s2_interior_ff ?
                cool_heat(s2_sum_ff, warm_ff, cold_ff, cool_hi_ff, cool_lo_ff, cool_cold_ff)
                : s2_sum_ff[7:0];
      if (cmd.clear_en) begin
         wr_en   = 1'b1;
         wr_addr = {1'b0, clr_addr_ff};
         wr_data = '0;
      end else if (s2_valid_ff) begin
         wr_en   = 1'b1;
      end else if (seed_hit) begin
         wr_en   = 1'b1;
         wr_addr = {active_bank_ff, RW'(FRAME_HEIGHT - 2), req_col_idx};
         wr_data = req_seed_heat;
      end
   end

   always_comb begin
      op_in       = cmd.accept ? req_opcode : op_ff;
      read_ok_in  = cmd.accept ? (row_ok && col_ok) : read_ok_ff;
      rsp_heat_in = rsp_heat_ff;
      rsp_op_in   = rsp_op_ff;
      if (cmd.load_rsp) begin
         rsp_heat_in = ((op_ff == fefu_pkg::OP_READ) && read_ok_ff) ? rd_a_data : '0;
         rsp_op_in   = op_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff        <= fefu_pkg::WARM_RST;
         cold_ff        <= fefu_pkg::COLD_RST;
         cool_hi_ff     <= fefu_pkg::COOL_HI_RST;
         cool_lo_ff     <= fefu_pkg::COOL_LO_RST;
         cool_cold_ff   <= fefu_pkg::COOL_COLD_RST;
         active_bank_ff <= 1'b0;
         clr_addr_ff    <= '0;
         slot_ff        <= '0;
         row_ff         <= '0;
         s1_run_ff      <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         warm_ff        <= warm_in;
         cold_ff        <= cold_in;
         cool_hi_ff     <= cool_hi_in;
         cool_lo_ff     <= cool_lo_in;
         cool_cold_ff   <= cool_cold_in;
         active_bank_ff <= active_bank_in;
         clr_addr_ff    <= clr_addr_in;
         slot_ff        <= slot_in;
         row_ff         <= row_in;
         s1_run_ff      <= s1_run_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_interior_ff <= s1_interior_in;
      s1_addr_ff     <= s1_addr_in;
      s2_interior_ff <= s2_interior_in;
      s2_addr_ff     <= s2_addr_in;
      s2_sum_ff      <= s2_sum_in;
      win0_ff        <= win0_in;
      win1_ff        <= win1_in;
      op_ff          <= op_in;
      read_ok_ff     <= read_ok_in;
      rsp_heat_ff    <= rsp_heat_in;
      rsp_op_ff      <= rsp_op_in;
   end

   fefu_frame_mem #(
      .ADDR_W(MEM_AW),
      .DATA_W(8)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_a_en  (rd_a_en),
      .rd_a_addr(rd_a_addr),
      .rd_a_data(rd_a_data),
      .rd_b_en  (rd_b_en),
      .rd_b_addr(rd_b_addr),
      .rd_b_data(rd_b_data)
   );

   assign st.clear_last = (clr_addr_ff == '1);
   assign st.req_step   = (req_opcode == fefu_pkg::OP_STEP);
   assign st.scan_last  = slot_last && row_last;
   assign st.pipe_busy  = s1_run_ff || s1_valid_ff || s2_valid_ff;

   assign rsp_read_heat   = rsp_heat_ff;
   assign rsp_done_opcode = rsp_op_ff;

   `FEFU_ASSERT(a_write_to_dst, clock, reset, s2_valid_ff |-> (wr_addr[MEM_AW-1] != active_bank_ff), "pipe write hit the source bank")
   `FEFU_ASSERT(a_scan_wrap, clock, reset, (cmd.scan_run && st.scan_last) |=> (slot_ff == '0 && row_ff == '0), "scan counters did not wrap")
   `FEFU_ASSERT(a_write_exclusive, clock, reset, s2_valid_ff |-> (!cmd.clear_en && !cmd.accept), "pipe write overlaps clear or transfer")

endmodule

`default_nettype wire

// ===== sv/fefu_ctrl.sv =====
// ----------------------------------------------------------------------------
// fefu_ctrl
// Sequencer: clear sweep, item dispatch, frame scan, drain and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fefu_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  fefu_pkg::fefu_status_type st,
   output fefu_pkg::fefu_cmd_type    cmd
);

   fefu_pkg::fefu_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fefu_pkg::S_CLEAR: begin
            if (st.clear_last) state_in = fefu_pkg::S_IDLE;
         end
         fefu_pkg::S_IDLE: begin
            if (req_tvalid) state_in = st.req_step ? fefu_pkg::S_STEP : fefu_pkg::S_DONE;
         end
         fefu_pkg::S_STEP: begin
            if (st.scan_last) state_in = fefu_pkg::S_DRAIN;
         end
         fefu_pkg::S_DRAIN: begin
            if (!st.pipe_busy) state_in = fefu_pkg::S_DONE;
         end
         fefu_pkg::S_DONE: begin
            if (rsp_free) state_in = fefu_pkg::S_IDLE;
         end
         default: state_in = fefu_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         fefu_pkg::S_CLEAR: cmd.clear_en = 1'b1;
         fefu_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         fefu_pkg::S_STEP:  cmd.scan_run = 1'b1;
         fefu_pkg::S_DRAIN: cmd.flip     = !st.pipe_busy;
         fefu_pkg::S_DONE:  cmd.load_rsp = rsp_free;
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fefu_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `FEFU_ASSERT_ALWAYS(a_reset_state, clock, reset |=> (state_ff == fefu_pkg::S_CLEAR && !rsp_valid_ff), "reset did not start the clear sweep")
   `FEFU_ASSERT(a_idle_pipe_empty, clock, reset, (state_ff == fefu_pkg::S_IDLE) |-> !st.pipe_busy, "scan pipe busy while idle")
   `FEFU_ASSERT(a_done_loads, clock, reset, (state_ff == fefu_pkg::S_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == fefu_pkg::S_IDLE), "free result register not loaded")

endmodule

`default_nettype wire

// ===== sv/fire_effect_frame_update.sv =====
// ----------------------------------------------------------------------------
// fire_effect_frame_update
// Double-banked heat frame with seed, frame step and pixel read operations.
// ----------------------------------------------------------------------------
// channel   direction  transfer on             contents
// req_      in         req_tvalid & tready     tuser opcode, tdata coords/seed
// rsp_      out        rsp_tvalid & tready     tuser opcode echo, tdata heat
// csr_      in         csr_we                  index 0..4, 8-bit write data
//
// Seed, read and no-op: the result loads from the done state once the output
// register is free; no new transfer is taken until the block is idle again.
// Step: the scan issues one pixel per cycle on two memory read ports plus one
// fill slot a row; the drain state then waits for the pipe to empty and flips
// the bank, and the result load follows.
// Reset: a clearing pass zeroes every address of bank 0, no transfers.
// A result not taken holds in the output register; the next item is accepted
// meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fire_effect_frame_update #(
   parameter int FRAME_WIDTH  = 64,
   parameter int FRAME_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_column[5:0], pixel_row[11:6],
                                    // seed_enable[12], seed_heat[20:13]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // read_heat[7:0]
   output logic [1:0]  rsp_tuser,   // done_opcode[1:0]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   fefu_pkg::fefu_cmd_type    cmd;
   fefu_pkg::fefu_status_type st;

   fefu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .st        (st),
      .cmd       (cmd)
   );

   fefu_datapath #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .FRAME_HEIGHT(FRAME_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_opcode     (req_tuser),
      .req_column     (req_tdata[5:0]),
      .req_row        (req_tdata[11:6]),
      .req_seed_enable(req_tdata[12]),
      .req_seed_heat  (req_tdata[20:13]),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_read_heat  (rsp_tdata),
      .rsp_done_opcode(rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fire effect frame update block. A queue-fed
// driver offers seed, step, read and no-op transfers. A local copy of both
// heat banks and the cooling registers predicts every response. A monitor
// compares each response field by field, in order. The run sweeps several
// cooling settings and flow-control modes and includes one long response
// stall.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FW = 64;
   localparam int FH = 64;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam logic [1:0] OP_NOP = 2'd3;
   localparam logic [2:0] REG_SPARE_LO = 3'd5;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [1:0] op;
      logic [5:0] col;
      logic [5:0] row;
      logic       seed_en;
      logic [7:0] seed_heat;
   } fire_req_type;

   typedef struct packed {
      logic [7:0] heat;
      logic [1:0] op;
   } fire_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   // heat frame copy and cooling registers
   logic [7:0] heat_bank [0:1][0:FW*FH-1];
   logic       cur_bank = 1'b0;
   logic [7:0] cfg_warm = fefu_pkg::WARM_RST;
   logic [7:0] cfg_cold = fefu_pkg::COLD_RST;
   logic [3:0] cfg_cool_hi = fefu_pkg::COOL_HI_RST;
   logic [3:0] cfg_cool_lo = fefu_pkg::COOL_LO_RST;
   logic [3:0] cfg_cool_cold = fefu_pkg::COOL_COLD_RST;

   fire_req_type pending_q [$];
   fire_rsp_type heat_expect_q [$];
   fire_req_type offered_req = '0;

   int send_idle_pct = 19;
   int recv_idle_pct = 79;
   logic rsp_hold = 1'b0;
   int err_count = 0;
   int cycle_count = 0;
   int rsp_count = 0;
   int op_count [0:3] = '{0, 0, 0, 0};
   int setting_count = 1;

   fire_effect_frame_update u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      for (int b = 0; b < 2; b++) begin
         for (int i = 0; i < FW*FH; i++) begin
            heat_bank[b][i] = 8'd0;
         end
      end
   end

   function automatic logic [7:0] cooled_heat(int sum);
      int q;
      int warm;
      int cold;
      q = sum;
      warm = 4 * int'(cfg_warm);
      cold = 4 * int'(cfg_cold);
      if (q > warm) q = q - 4 * int'(cfg_cool_hi);
      if (q <= warm) q = q - 4 * int'(cfg_cool_lo);
      if (q < cold) q = q - 4 * int'(cfg_cool_cold);
      if (q < 0) q = 0;
      return 8'(q >> 2);
   endfunction

   function automatic void advance_heat();
      logic nb;
      int at;
      int sum;
      nb = ~cur_bank;
      for (int r = 0; r < FH; r++) begin
         for (int c = 0; c < FW; c++) begin
            at = r * FW + c;
            if (r + 3 <= FH && c >= 1 && c + 2 <= FW) begin
               sum = int'(heat_bank[cur_bank][at+FW-1]) + int'(heat_bank[cur_bank][at+FW])
                   + int'(heat_bank[cur_bank][at+FW+1]) + int'(heat_bank[cur_bank][at+2*FW]);
               heat_bank[nb][at] = cooled_heat(sum);
            end else begin
               heat_bank[nb][at] = heat_bank[cur_bank][at];
            end
         end
      end
      cur_bank = nb;
   endfunction

   function automatic fire_rsp_type apply_fire_req(fire_req_type rq);
      fire_rsp_type rs;
      rs.heat = 8'd0;
      rs.op = rq.op;
      case (rq.op)
         fefu_pkg::OP_SEED: begin
            if (rq.seed_en) heat_bank[cur_bank][(FH-2)*FW + int'(rq.col)] = rq.seed_heat;
         end
         fefu_pkg::OP_STEP: advance_heat();
         fefu_pkg::OP_READ: rs.heat = heat_bank[cur_bank][int'(rq.row)*FW + int'(rq.col)];
         default: ;
      endcase
      return rs;
   endfunction

   function automatic fire_req_type mk_req(logic [1:0] op, logic [5:0] col, logic [5:0] row,
                                           logic en, logic [7:0] heat);
      fire_req_type rq;
      rq.op = op;
      rq.col = col;
      rq.row = row;
      rq.seed_en = en;
      rq.seed_heat = heat;
      return rq;
   endfunction

   task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s: got %0h expected %0h (response %0d, cycle %0d)",
               field, got, want, rsp_count, cycle_count);
      err_count++;
   endtask

   // driver
   always @(posedge clock) begin : req_driver
      fire_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            heat_expect_q.push_back(apply_fire_req(offered_req));
            op_count[offered_req.op]++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_q.pop_front();
               offered_req = nxt;
               req_tvalid <= 1'b1;
               req_tdata <= {3'b000, nxt.seed_heat, nxt.seed_en, nxt.row, nxt.col};
               req_tuser <= nxt.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      fire_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (heat_expect_q.size() == 0) begin
               report_mismatch("unexpected response, tuser", {6'd0, rsp_tuser}, 8'd0);
            end else begin
               want = heat_expect_q.pop_front();
               if (rsp_tuser !== want.op)
                  report_mismatch("done_opcode", {6'd0, rsp_tuser}, {6'd0, want.op});
               if (rsp_tdata !== want.heat)
                  report_mismatch("read_heat", rsp_tdata, want.heat);
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("timeout after %0d cycles, %0d responses pending", cycle_count,
               heat_expect_q.size());
      $display("Some tests failed");
      $finish;
   end

   task automatic csr_write(logic [2:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         fefu_pkg::REG_WARM:      cfg_warm = val;
         fefu_pkg::REG_COLD:      cfg_cold = val;
         fefu_pkg::REG_COOL_HI:   cfg_cool_hi = val[3:0];
         fefu_pkg::REG_COOL_LO:   cfg_cool_lo = val[3:0];
         fefu_pkg::REG_COOL_COLD: cfg_cool_cold = val[3:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_cooling(logic [7:0] warm, logic [7:0] cold, logic [7:0] hi,
                               logic [7:0] lo, logic [7:0] extra);
      csr_write(fefu_pkg::REG_WARM, warm);
      csr_write(fefu_pkg::REG_COLD, cold);
      csr_write(fefu_pkg::REG_COOL_HI, hi);
      csr_write(fefu_pkg::REG_COOL_LO, lo);
      csr_write(fefu_pkg::REG_COOL_COLD, extra);
      setting_count++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_tvalid || heat_expect_q.size() != 0);
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      @(posedge clock);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   task automatic hold_responses(int cycles);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   // mostly seeds into the hot row, frame steps, and reads near the bottom
   task automatic queue_fire_burst(int n, bit with_steps);
      int pick;
      logic [5:0] row;
      logic [7:0] heat;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (!with_steps && pick >= 40 && pick < 55) pick = pick + 15;
         if (pick < 40) begin
            heat = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(160, 255)) : 8'($urandom);
            pending_q.push_back(mk_req(fefu_pkg::OP_SEED, 6'($urandom), 6'($urandom),
                                       $urandom_range(0, 9) != 0, heat));
         end else if (pick < 55) begin
            pending_q.push_back(mk_req(fefu_pkg::OP_STEP, 6'($urandom), 6'($urandom),
                                       1'($urandom), 8'($urandom)));
         end else if (pick < 90) begin
            row = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(48, 63)) : 6'($urandom);
            pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'($urandom), row,
                                       1'($urandom), 8'($urandom)));
         end else begin
            pending_q.push_back(mk_req(OP_NOP, 6'($urandom), 6'($urandom),
                                       1'($urandom), 8'($urandom)));
         end
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset cooling values, cleared frame, edges of the seed row
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd0, 6'd0, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd63, 6'd63, 1'b1, 8'hFF));
      pending_q.push_back(mk_req(fefu_pkg::OP_SEED, 6'd5, 6'd0, 1'b0, 8'd200));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd5, 6'd62, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_SEED, 6'd0, 6'd63, 1'b1, 8'hFF));
      pending_q.push_back(mk_req(fefu_pkg::OP_SEED, 6'd63, 6'd0, 1'b1, 8'hFF));
      pending_q.push_back(mk_req(fefu_pkg::OP_SEED, 6'd31, 6'd17, 1'b1, 8'd128));
      pending_q.push_back(mk_req(fefu_pkg::OP_SEED, 6'd32, 6'd42, 1'b1, 8'd1));
      pending_q.push_back(mk_req(fefu_pkg::OP_SEED, 6'd30, 6'd21, 1'b1, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd0, 6'd62, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd63, 6'd62, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd31, 6'd62, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_STEP, 6'd63, 6'd63, 1'b1, 8'hFF));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd31, 6'd61, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd32, 6'd61, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd0, 6'd61, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd0, 6'd62, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd31, 6'd62, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_STEP, 6'd0, 6'd0, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd31, 6'd60, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd31, 6'd61, 1'b0, 8'd0));
      pending_q.push_back(mk_req(OP_NOP, 6'd63, 6'd63, 1'b1, 8'hFF));
      pending_q.push_back(mk_req(OP_NOP, 6'd0, 6'd0, 1'b0, 8'd0));
      pending_q.push_back(mk_req(fefu_pkg::OP_READ, 6'd63, 6'd63, 1'b0, 8'd0));
      wait_drained();

      queue_fire_burst(22, 1'b1);
      wait_drained();

      // strongest cooling, 4-bit fields written with upper bits set
      load_cooling(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      csr_write(REG_SPARE_LO, 8'h00);
      csr_write(REG_SPARE_HI, 8'h00);
      queue_fire_burst(22, 1'b1);
      wait_drained();

      set_idling(79, 19);
      load_cooling(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      csr_write(REG_SPARE_LO, 8'hFF);
      csr_write(REG_SPARE_HI, 8'hA5);
      queue_fire_burst(22, 1'b1);
      wait_drained();

      load_cooling(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      queue_fire_burst(22, 1'b1);
      wait_drained();

      set_idling(0, 0);
      load_cooling(8'($urandom_range(40, 120)), 8'($urandom_range(0, 40)),
                   8'($urandom), 8'($urandom), 8'($urandom));
      queue_fire_burst(12, 1'b0);
      fork
         hold_responses(300);
      join_none
      queue_fire_burst(18, 1'b1);
      wait_drained();

      repeat (16) @(posedge clock);
      if (heat_expect_q.size() != 0)
         report_mismatch("responses missing, count", 8'd0, 8'(heat_expect_q.size()));

      $display("Checked %0d responses: %0d seeds, %0d frame steps, %0d reads, %0d no-ops",
               rsp_count, op_count[fefu_pkg::OP_SEED], op_count[fefu_pkg::OP_STEP],
               op_count[fefu_pkg::OP_READ], op_count[OP_NOP]);
      $display("Cooling settings used: %0d, under three flow-control modes and a long stall",
               setting_count);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/fefu_pkg.sv
sv/fefu_frame_mem.sv
sv/fefu_datapath.sv
sv/fefu_ctrl.sv
sv/fire_effect_frame_update.sv
bench/testbench.sv
